### rtl/skt_pkg.sv
package skt_pkg;

   localparam int KEY_W     = 32;
   localparam int DATA_W    = 32;
   localparam int ENTRIES_W = 5;

   typedef enum logic [1:0] {
      CMD_INSERT     = 2'd0,
      CMD_LOOKUP     = 2'd1,
      CMD_REMOVE     = 2'd2,
      CMD_REMOVE_MIN = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_DUP  = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_SCAN,
      S_APPLY
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  op_count;
      logic [DATA_W-1:0]  balance;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [KEY_W-1:0]       found_key;
      logic [DATA_W-1:0]      found_ops;
      logic [DATA_W-1:0]      found_balance;
      logic [ENTRIES_W-1:0]   entries;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  ops;
      logic [DATA_W-1:0]  bal;
   } entry_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic       compare;
      logic       scan;
      logic       apply_ins;
      logic       apply_rm;
      logic       is_min;
      entry_type  req;
   } ctrl_type;

   // Handed from a cell to its right-hand neighbor.
   typedef struct packed {
      logic       head;
      logic       occ;
      logic       below;
      entry_type  entry;
      logic       found_hit;
      entry_type  found;
   } link_type;

endpackage

### rtl/skt_cell.sv
module skt_cell
   import skt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  ctrl_type   ctrl,
   input  logic       occ,
   input  link_type   left,
   input  entry_type  right_entry,
   output link_type   link_out,
   output entry_type  entry_out
);

   entry_type entry_ff, entry_in;
   logic      below_ff, below_in;
   logic      hit_ff, hit_in;
   logic      found_hit_ff, found_hit_in;
   entry_type found_ff, found_in;

   always_comb begin
      below_in     = below_ff;
      hit_in       = hit_ff;
      found_hit_in = found_hit_ff;
      found_in     = found_ff;
      entry_in     = entry_ff;

      if (ctrl.compare) begin
         below_in = occ & (entry_ff.key < ctrl.req.key);
         if (ctrl.is_min) begin
            hit_in = occ & left.head;
         end else begin
            hit_in = occ & (entry_ff.key == ctrl.req.key);
         end
      end

      // Pass the matching entry down the row, one cell per cycle.
      if (ctrl.scan) begin
         found_hit_in = left.found_hit | hit_ff;
         found_in     = hit_ff ? entry_ff : left.found;
      end

      if (ctrl.apply_ins) begin
         if (!below_ff && left.below) begin
            entry_in = ctrl.req;
         end else if (left.occ && !left.below) begin
            entry_in = left.entry;
         end
      end else if (ctrl.apply_rm) begin
         // close the gap: every cell from the removed one up pulls from the right
         if (ctrl.is_min || !below_ff) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      found_ff <= found_in;
      if (reset) begin
         below_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         found_hit_ff <= 1'b0;
      end else begin
         below_ff     <= below_in;
         hit_ff       <= hit_in;
         found_hit_ff <= found_hit_in;
      end
   end

   assign link_out.head      = 1'b0;
   assign link_out.occ       = occ;
   assign link_out.below     = below_ff;
   assign link_out.entry     = entry_ff;
   assign link_out.found_hit = found_hit_ff;
   assign link_out.found     = found_ff;
   assign entry_out          = entry_ff;

endmodule

### rtl/sorted_key_table.sv
// Sorted key table: holds up to CAPACITY entries (key, op count, balance)
// in ascending key order, one entry per cell of a row.
// Request channel (req_valid/req_ready/req_payload) takes a command:
// insert, lookup by key, remove by key or remove smallest. Each request
// gives exactly one response on rsp_valid/rsp_ready/rsp_payload with a
// status, the fields of the entry found or removed and the entry count.
// Timing: one request is in flight at a time. After acceptance the cells
// compare, the matching entry is carried down the row cell by cell, and
// a final step shifts the row and loads the response register. A new
// request is taken only once that step is done and the table is idle
// again. The length of the cell row sets the length of the scan.
// Reset empties the table; entry contents are not cleared.
// When the receiver stalls, the response is held in its register, the
// next request is still accepted and waits in the final step until the
// response register frees up.
module sorted_key_table
   import skt_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_payload,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CNT_W  = $clog2(CAPACITY);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   ctrl_type  ctrl;
   logic [CAPACITY-1:0] occ;
   link_type  links [CAPACITY+1];
   entry_type entries_out [CAPACITY+1];

   logic slot_free, full, found, do_apply, last_cnt;
   logic [31:0] fill_ext;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full      = (fill_ff == FILL_W'(CAPACITY));
   assign found     = links[CAPACITY].found_hit;
   assign last_cnt  = (cnt_ff == CNT_W'(CAPACITY - 1));

   // Left end: acts as an occupied entry below every key, so cell 0 is
   // the insert place on an empty or all-greater row.
   assign links[0].head      = 1'b1;
   assign links[0].occ       = 1'b1;
   assign links[0].below     = 1'b1;
   assign links[0].entry     = '0;
   assign links[0].found_hit = 1'b0;
   assign links[0].found     = '0;
   assign entries_out[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i] = (FILL_W'(i) < fill_ff);
      skt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .occ         (occ[i]),
         .left        (links[i]),
         .right_entry (entries_out[i+1]),
         .link_out    (links[i+1]),
         .entry_out   (entries_out[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_COMPARE;
         S_COMPARE: state_in = S_SCAN;
         S_SCAN:    if (last_cnt) state_in = S_APPLY;
         S_APPLY:   if (slot_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      do_apply       = 1'b0;
      ctrl.compare   = 1'b0;
      ctrl.scan      = 1'b0;
      ctrl.apply_ins = 1'b0;
      ctrl.apply_rm  = 1'b0;
      ctrl.is_min    = (req_ff.command == CMD_REMOVE_MIN);
      ctrl.req.key   = req_ff.key;
      ctrl.req.ops   = req_ff.op_count;
      ctrl.req.bal   = req_ff.balance;
      unique case (state_ff)
         S_IDLE:    req_ready = 1'b1;
         S_COMPARE: ctrl.compare = 1'b1;
         S_SCAN:    ctrl.scan = 1'b1;
         S_APPLY:   do_apply = slot_free;
         default:   req_ready = 1'b0;
      endcase
      if (do_apply) begin
         ctrl.apply_ins = (req_ff.command == CMD_INSERT) && !found && !full;
         ctrl.apply_rm  = (req_ff.command == CMD_REMOVE ||
                           req_ff.command == CMD_REMOVE_MIN) && found;
      end
   end

   assign cnt_in = (state_ff == S_SCAN) ? (cnt_ff + CNT_W'(1)) : '0;

   always_comb begin
      fill_in = fill_ff;
      if (ctrl.apply_ins) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (ctrl.apply_rm) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   assign fill_ext = 32'(fill_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (do_apply) begin
         rsp_valid_in          = 1'b1;
         rsp_in.entries        = fill_ext[ENTRIES_W-1:0];
         rsp_in.found_key      = '0;
         rsp_in.found_ops      = '0;
         rsp_in.found_balance  = '0;
         if (req_ff.command == CMD_INSERT) begin
            priority if (found) begin
               rsp_in.status = ST_DUP;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status = ST_DONE;
            end
         end else if (found) begin
            rsp_in.status        = ST_DONE;
            rsp_in.found_key     = links[CAPACITY].found.key;
            rsp_in.found_ops     = links[CAPACITY].found.ops;
            rsp_in.found_balance = links[CAPACITY].found.bal;
         end else begin
            rsp_in.status = ST_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
